/* rtl/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg: shared types and constants of the stepper speed ramp
// Field widths, timer clock, command kinds, ramp modes and back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

    localparam int FREQ_W    = 19;
    localparam int RELOAD_W  = 20;
    localparam int RPM_W     = 16;
    localparam int REQ_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int TIMER_CLOCK_HZ = 1000000;
    localparam int TIMER_W        = $clog2(TIMER_CLOCK_HZ + 1);
    localparam int DIV_IDX_W      = (TIMER_W > 1) ? $clog2(TIMER_W) : 1;
    localparam logic [TIMER_W-1:0] DIVIDEND = TIMER_W'(TIMER_CLOCK_HZ);

    // rpm*10 fits 20 bits; floor(x/3) = (x*ceil(2^22/3)) >> 22 for x < 2^21
    localparam int SCALED_W = 20;
    localparam int RECIP_W  = 21;
    localparam int RECIP_SH = 22;
    localparam logic [RECIP_W-1:0] RECIP3 = 21'd1398102;
    localparam int PROD_W = SCALED_W + RECIP_W;

    localparam logic [RELOAD_W-1:0] RELOAD_MAX = '1;

    localparam logic [REQ_W-1:0] REQ_ACCEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DECEL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_STP = 2'd3;

    typedef enum logic [1:0] {
        CMD_ACCEL,
        CMD_DECEL,
        CMD_TICK,
        CMD_NOP
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_UP,
        MODE_DOWN
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_DONE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [FREQ_W-1:0]  goal;
        logic               stop;
    } t_cmd;

    typedef struct packed {
        logic [FREQ_W-1:0] min_freq;
        logic [FREQ_W-1:0] max_freq;
        logic [FREQ_W-1:0] accel_step;
        logic [FREQ_W-1:0] decel_step;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/ssr_front.sv */
// ----------------------------------------------------------------------------
// ssr_front: request intake and classification
// Converts rpm to a goal frequency, clamps accelerate goals and pushes a command word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [ssr_pkg::REQ_W-1:0]  i_req_type,
    input  wire logic [ssr_pkg::RPM_W-1:0]  i_target_rpm,
    input  wire ssr_pkg::t_cfg              i_cfg,
    output logic                            o_push,
    output ssr_pkg::t_cmd                   o_cmd,
    input  wire logic                       i_full
);

    logic                           r_s1_valid;
    logic [ssr_pkg::REQ_W-1:0]      r_s1_req;
    logic                           r_s1_zero;
    logic [ssr_pkg::PROD_W-1:0]     r_s1_prod;

    logic [ssr_pkg::SCALED_W-1:0]   scaled;
    logic [ssr_pkg::FREQ_W-1:0]     conv;
    logic                           accept;

    assign scaled = {1'b0, i_target_rpm, 3'b000} + {3'b000, i_target_rpm, 1'b0};
    assign o_push = r_s1_valid && !i_full;
    assign o_in_ready = !r_s1_valid || !i_full;
    assign accept = i_in_valid && o_in_ready;
    assign conv = r_s1_prod[ssr_pkg::RECIP_SH +: ssr_pkg::FREQ_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (o_push) begin
            r_s1_valid <= 1'b0;
        end
        if (accept) begin
            r_s1_req  <= i_req_type;
            r_s1_zero <= (i_target_rpm == '0);
            r_s1_prod <= ssr_pkg::PROD_W'(scaled) * ssr_pkg::PROD_W'(ssr_pkg::RECIP3);
        end
    end

    always_comb begin
        o_cmd.stop = r_s1_zero;
        o_cmd.goal = conv;
        case (r_s1_req)
            ssr_pkg::REQ_ACCEL: begin
                o_cmd.kind = ssr_pkg::CMD_ACCEL;
                if (conv > i_cfg.max_freq) begin
                    o_cmd.goal = i_cfg.max_freq;
                end else if (conv < i_cfg.min_freq) begin
                    o_cmd.goal = i_cfg.min_freq;
                end
            end
            ssr_pkg::REQ_DECEL: begin
                o_cmd.kind = ssr_pkg::CMD_DECEL;
                if (r_s1_zero) begin
                    o_cmd.goal = i_cfg.min_freq;
                end
            end
            ssr_pkg::REQ_TICK: begin
                o_cmd.kind = ssr_pkg::CMD_TICK;
            end
            default: begin
                o_cmd.kind = ssr_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ssr_queue.sv */
// ----------------------------------------------------------------------------
// ssr_queue: two-entry command queue
// Decouples the intake from the ramp engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ssr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output ssr_pkg::t_cmd       o_cmd
);

    ssr_pkg::t_cmd  r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/ssr_divider.sv */
// ----------------------------------------------------------------------------
// ssr_divider: restoring divider for the timer period
// Divides the timer clock by a frequency, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [ssr_pkg::FREQ_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic [ssr_pkg::TIMER_W-1:0]         o_quotient
);

    logic                               r_busy;
    logic                               r_done;
    logic [ssr_pkg::DIV_IDX_W-1:0]      r_idx;
    logic [ssr_pkg::FREQ_W-1:0]         r_div;
    logic [ssr_pkg::FREQ_W-1:0]         r_rem;
    logic [ssr_pkg::TIMER_W-1:0]        r_quo;

    logic [ssr_pkg::FREQ_W:0]           shifted;
    logic                               ge;

    assign shifted = {r_rem, ssr_pkg::DIVIDEND[r_idx]};
    assign ge = (shifted >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_idx == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_idx <= ssr_pkg::DIV_IDX_W'(ssr_pkg::TIMER_W - 1);
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_idx <= r_idx - 1'b1;
            r_rem <= ge ? ssr_pkg::FREQ_W'(shifted - {1'b0, r_div})
                        : ssr_pkg::FREQ_W'(shifted);
            r_quo <= {r_quo[ssr_pkg::TIMER_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

/* rtl/ssr_back.sv */
// ----------------------------------------------------------------------------
// ssr_back: ramp engine
// Applies commands and ramp steps, computes the reload, holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ssr_pkg::t_cfg                  i_cfg,
    input  wire logic                           i_q_valid,
    input  wire ssr_pkg::t_cmd                  i_q_cmd,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_pwm_enable,
    output logic [ssr_pkg::RELOAD_W-1:0]        o_period_reload,
    output logic [ssr_pkg::FREQ_W-1:0]          o_step_frequency,
    output logic                                o_ramping
);

    ssr_pkg::t_state                r_state, n_state;
    ssr_pkg::t_mode                 r_mode, n_mode;
    logic [ssr_pkg::FREQ_W-1:0]     r_cur, n_cur;
    logic [ssr_pkg::FREQ_W-1:0]     r_goal, n_goal;
    logic                           r_stop, n_stop;
    logic                           r_pwm, n_pwm;
    logic [ssr_pkg::RELOAD_W-1:0]   r_reload, n_reload;
    logic                           r_reach, n_reach;
    logic                           r_out_valid, n_out_valid;
    logic                           r_o_pwm, n_o_pwm;
    logic [ssr_pkg::RELOAD_W-1:0]   r_o_reload, n_o_reload;
    logic [ssr_pkg::FREQ_W-1:0]     r_o_freq, n_o_freq;
    logic                           r_o_ramp, n_o_ramp;

    logic                           div_start;
    logic                           div_done;
    logic [ssr_pkg::TIMER_W-1:0]    div_quo;
    logic [31:0]                    quo_ext;
    logic [ssr_pkg::FREQ_W-1:0]     up_diff;
    logic [ssr_pkg::FREQ_W-1:0]     dn_diff;
    logic                           up_go;
    logic                           dn_go;

    ssr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (n_cur),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign quo_ext = 32'(div_quo);
    assign up_diff = r_goal - r_cur;
    assign dn_diff = r_cur - r_goal;
    assign up_go = (r_mode == ssr_pkg::MODE_UP) && (r_cur < r_goal);
    assign dn_go = (r_mode == ssr_pkg::MODE_DOWN) && (r_cur > r_goal);

    assign o_out_valid      = r_out_valid;
    assign o_pwm_enable     = r_o_pwm;
    assign o_period_reload  = r_o_reload;
    assign o_step_frequency = r_o_freq;
    assign o_ramping        = r_o_ramp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssr_pkg::ST_IDLE;
            r_mode      <= ssr_pkg::MODE_IDLE;
            r_cur       <= '0;
            r_goal      <= '0;
            r_stop      <= 1'b0;
            r_pwm       <= 1'b0;
            r_reload    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cur       <= n_cur;
            r_goal      <= n_goal;
            r_stop      <= n_stop;
            r_pwm       <= n_pwm;
            r_reload    <= n_reload;
            r_out_valid <= n_out_valid;
        end
        r_reach    <= n_reach;
        r_o_pwm    <= n_o_pwm;
        r_o_reload <= n_o_reload;
        r_o_freq   <= n_o_freq;
        r_o_ramp   <= n_o_ramp;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cur       = r_cur;
        n_goal      = r_goal;
        n_stop      = r_stop;
        n_pwm       = r_pwm;
        n_reload    = r_reload;
        n_reach     = r_reach;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_pwm     = r_o_pwm;
        n_o_reload  = r_o_reload;
        n_o_freq    = r_o_freq;
        n_o_ramp    = r_o_ramp;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        case (r_state)
            ssr_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ssr_pkg::ST_STEP;
                    case (i_q_cmd.kind)
                        ssr_pkg::CMD_ACCEL: begin
                            n_goal = i_q_cmd.goal;
                            n_stop = 1'b0;
                            n_pwm  = 1'b1;
                            n_mode = ssr_pkg::MODE_UP;
                        end
                        ssr_pkg::CMD_DECEL: begin
                            n_goal = i_q_cmd.goal;
                            n_stop = i_q_cmd.stop;
                            n_mode = ssr_pkg::MODE_DOWN;
                        end
                        ssr_pkg::CMD_TICK: begin
                        end
                        default: begin
                            n_state = ssr_pkg::ST_EMIT;
                        end
                    endcase
                end
            end
            ssr_pkg::ST_STEP: begin
                if (up_go || dn_go) begin
                    if (up_go) begin
                        n_reach = (up_diff <= i_cfg.accel_step);
                        n_cur = n_reach ? r_goal : r_cur + i_cfg.accel_step;
                    end else begin
                        n_reach = (dn_diff <= i_cfg.decel_step);
                        n_cur = n_reach ? r_goal : r_cur - i_cfg.decel_step;
                    end
                    if (n_cur == '0) begin
                        n_reload = ssr_pkg::RELOAD_MAX;
                        n_state  = ssr_pkg::ST_DONE;
                    end else begin
                        n_state = ssr_pkg::ST_DIV;
                    end
                end else begin
                    // no ramp running, or ramp already at or past its goal: end it here
                    n_reach = (r_mode != ssr_pkg::MODE_IDLE);
                    n_state = ssr_pkg::ST_DONE;
                end
            end
            ssr_pkg::ST_DIV: begin
                if (div_done) begin
                    if (quo_ext == 32'd0) begin
                        n_reload = '0;
                    end else if ((quo_ext - 32'd1) > 32'(ssr_pkg::RELOAD_MAX)) begin
                        n_reload = ssr_pkg::RELOAD_MAX;
                    end else begin
                        n_reload = ssr_pkg::RELOAD_W'(quo_ext - 32'd1);
                    end
                    n_state = ssr_pkg::ST_DONE;
                end
            end
            ssr_pkg::ST_DONE: begin
                if (r_reach) begin
                    n_mode = ssr_pkg::MODE_IDLE;
                    if (r_stop) begin
                        n_pwm  = 1'b0;
                        n_stop = 1'b0;
                    end
                end
                n_state = ssr_pkg::ST_EMIT;
            end
            ssr_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_pwm     = r_pwm;
                    n_o_reload  = r_reload;
                    n_o_freq    = r_cur;
                    n_o_ramp    = (r_mode != ssr_pkg::MODE_IDLE);
                    n_state     = ssr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ssr_pkg::ST_IDLE;
            end
        endcase
        if ((r_state == ssr_pkg::ST_STEP) && (n_state == ssr_pkg::ST_DIV)) begin
            div_start = 1'b1;
        end
    end

    a_idle_no_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ssr_pkg::MODE_IDLE) |-> !r_stop)
        else $error("stop flag left set on an idle ramp");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssr_pkg::ST_DIV) |-> (r_cur != '0))
        else $error("divider running on a zero frequency");

    a_up_below_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ssr_pkg::ST_EMIT) && (r_mode == ssr_pkg::MODE_UP)) |-> (r_cur < r_goal))
        else $error("upward ramp still running at or above its goal");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ssr_pkg::ST_DIV))
        else $error("divider finished outside the divide state");

endmodule

`default_nettype wire

/* rtl/stepper_speed_ramp_core.sv */
// ----------------------------------------------------------------------------
// stepper_speed_ramp_core: linear stepper speed ramp generator
// Turns speed commands and ramp ticks into step frequency and timer reload.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  in      | sink      | i_in_valid / o_in_ready   | i_req_type, i_target_rpm
//  out     | source    | o_out_valid / i_out_ready | o_pwm_enable, o_period_reload,
//          |           |                           | o_step_frequency, o_ramping
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A word that moves the frequency is answered through the bit-serial reload
//  divider; the engine takes the next word only after it has emitted the result
//  of the last. Words that leave the frequency alone or drop it to zero skip the
//  divider, and unused codes skip the step and done states as well.
//  The intake holds one word and the queue two more while the engine is busy.
//  A result waits in the output register; the engine stalls only when it is full.
//  Synchronous active-low reset restores the register defaults and stops output.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_speed_ramp_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [ssr_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [ssr_pkg::RPM_W-1:0]      i_target_rpm,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_pwm_enable,
    output logic [ssr_pkg::RELOAD_W-1:0]        o_period_reload,
    output logic [ssr_pkg::FREQ_W-1:0]          o_step_frequency,
    output logic                                o_ramping,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssr_pkg::FREQ_W-1:0]     i_cfg_data
);

    ssr_pkg::t_cfg  r_cfg;
    ssr_pkg::t_cmd  push_cmd;
    ssr_pkg::t_cmd  head_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_freq   <= ssr_pkg::FREQ_W'(100);
            r_cfg.max_freq   <= ssr_pkg::FREQ_W'(4000);
            r_cfg.accel_step <= ssr_pkg::FREQ_W'(100);
            r_cfg.decel_step <= ssr_pkg::FREQ_W'(100);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssr_pkg::CFG_MIN_FREQ:  r_cfg.min_freq   <= i_cfg_data;
                ssr_pkg::CFG_MAX_FREQ:  r_cfg.max_freq   <= i_cfg_data;
                ssr_pkg::CFG_ACCEL_STP: r_cfg.accel_step <= i_cfg_data;
                ssr_pkg::CFG_DECEL_STP: r_cfg.decel_step <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ssr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_target_rpm (i_target_rpm),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .i_full       (full)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    ssr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (head_valid),
        .i_q_cmd          (head_cmd),
        .o_q_pop          (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_pwm_enable     (o_pwm_enable),
        .o_period_reload  (o_period_reload),
        .o_step_frequency (o_step_frequency),
        .o_ramping        (o_ramping)
    );

endmodule

`default_nettype wire

/* sim/stepper_speed_ramp_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp_core_test: self-checking bench for the speed ramp core
// Drives commands and ramp ticks with random gaps and output stalls, runs
// through several register settings, and compares every output word with an
// in-bench prediction of frequency, reload, step output and ramp status.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_core_test;

    localparam logic [ssr_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int unsigned NUM_PHASES      = 10;
    localparam int unsigned ITEMS_PER_PHASE = 155;
    localparam int unsigned IDLE_LIMIT      = 5000;
    localparam int unsigned TAIL_CYCLES     = 64;
    localparam int unsigned MAX_REPORTS     = 100;

    typedef struct packed {
        logic [ssr_pkg::REQ_W-1:0] req;
        logic [ssr_pkg::RPM_W-1:0] rpm;
    } t_ramp_req;

    typedef struct packed {
        logic                         pwm;
        logic [ssr_pkg::RELOAD_W-1:0] reload;
        logic [ssr_pkg::FREQ_W-1:0]   freq;
        logic                         ramping;
    } t_speed_word;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ssr_pkg::REQ_W-1:0]     req_type = '0;
    logic [ssr_pkg::RPM_W-1:0]     target_rpm = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          pwm_enable;
    logic [ssr_pkg::RELOAD_W-1:0]  period_reload;
    logic [ssr_pkg::FREQ_W-1:0]    step_frequency;
    logic                          ramping;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ssr_pkg::FREQ_W-1:0]    cfg_data = '0;

    // predicted block state and register copies
    logic [ssr_pkg::FREQ_W-1:0]   freq_now = '0;
    logic [ssr_pkg::FREQ_W-1:0]   freq_goal = '0;
    ssr_pkg::t_mode               ramp_dir = ssr_pkg::MODE_IDLE;
    logic                         stop_pending = 1'b0;
    logic                         pwm_running = 1'b0;
    logic [ssr_pkg::RELOAD_W-1:0] reload_now = '0;
    logic [ssr_pkg::FREQ_W-1:0]   lo_freq = 19'd100;
    logic [ssr_pkg::FREQ_W-1:0]   hi_freq = 19'd4000;
    logic [ssr_pkg::FREQ_W-1:0]   up_step = 19'd100;
    logic [ssr_pkg::FREQ_W-1:0]   down_step = 19'd100;

    t_ramp_req   pending_requests[$];
    t_speed_word speed_expected[$];
    t_ramp_req   next_req;

    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned gap_left = 0;
    int unsigned in_calm = 0;
    int unsigned stall_left = 0;
    int unsigned out_calm = 0;
    bit          in_fire = 1'b0;

    stepper_speed_ramp_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_target_rpm     (target_rpm),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_pwm_enable     (pwm_enable),
        .o_period_reload  (period_reload),
        .o_step_frequency (step_frequency),
        .o_ramping        (ramping),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int unsigned pick_pause(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ssr_pkg::RPM_W-1:0] pick_rpm();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return ssr_pkg::RPM_W'($urandom_range(0, 1300));
            default: return ssr_pkg::RPM_W'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [ssr_pkg::REQ_W-1:0] req,
                              input logic [ssr_pkg::RPM_W-1:0] rpm);
        pending_requests.push_back('{req: req, rpm: rpm});
    endtask

    // one word in, one predicted output word queued
    task automatic step_speed_ramp(input logic [ssr_pkg::REQ_W-1:0] req,
                                   input logic [ssr_pkg::RPM_W-1:0] rpm);
        int unsigned conv;
        int unsigned q;
        bit          moved;
        bit          reached;
        t_speed_word w;
        conv = (32'(rpm) * 10) / 3;
        moved = 1'b0;
        reached = 1'b0;
        if (req == ssr_pkg::REQ_ACCEL) begin
            // max is tested first, so min > max still yields max for high goals
            if (conv > hi_freq) freq_goal = hi_freq;
            else if (conv < lo_freq) freq_goal = lo_freq;
            else freq_goal = conv[ssr_pkg::FREQ_W-1:0];
            stop_pending = 1'b0;
            pwm_running = 1'b1;
            ramp_dir = ssr_pkg::MODE_UP;
        end else if (req == ssr_pkg::REQ_DECEL) begin
            freq_goal = (rpm == 0) ? lo_freq : conv[ssr_pkg::FREQ_W-1:0];
            stop_pending = (rpm == 0);
            ramp_dir = ssr_pkg::MODE_DOWN;
        end
        if (req != REQ_SPARE) begin
            if (ramp_dir == ssr_pkg::MODE_UP) begin
                if (freq_now >= freq_goal) begin
                    reached = 1'b1;
                end else begin
                    freq_now = (freq_goal - freq_now <= up_step) ? freq_goal : freq_now + up_step;
                    moved = 1'b1;
                    reached = (freq_now >= freq_goal);
                end
            end else if (ramp_dir == ssr_pkg::MODE_DOWN) begin
                if (freq_now <= freq_goal) begin
                    reached = 1'b1;
                end else begin
                    freq_now = (freq_now - freq_goal <= down_step) ? freq_goal
                                                                   : freq_now - down_step;
                    moved = 1'b1;
                    reached = (freq_now <= freq_goal);
                end
            end
            if (moved) begin
                if (freq_now == 0) begin
                    reload_now = ssr_pkg::RELOAD_MAX;
                end else begin
                    q = ssr_pkg::TIMER_CLOCK_HZ / freq_now;
                    if (q == 0) reload_now = '0;
                    else if (q - 1 > ssr_pkg::RELOAD_MAX) reload_now = ssr_pkg::RELOAD_MAX;
                    else reload_now = ssr_pkg::RELOAD_W'(q - 1);
                end
            end
            if (reached) begin
                ramp_dir = ssr_pkg::MODE_IDLE;
                if (stop_pending) begin
                    pwm_running = 1'b0;
                    stop_pending = 1'b0;
                end
            end
        end
        w.pwm = pwm_running;
        w.reload = reload_now;
        w.freq = freq_now;
        w.ramping = (ramp_dir != ssr_pkg::MODE_IDLE);
        speed_expected.push_back(w);
    endtask

    task automatic write_register(input logic [ssr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ssr_pkg::FREQ_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ssr_pkg::CFG_MIN_FREQ:  lo_freq = value;
            ssr_pkg::CFG_MAX_FREQ:  hi_freq = value;
            ssr_pkg::CFG_ACCEL_STP: up_step = value;
            ssr_pkg::CFG_DECEL_STP: down_step = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input word taken
    always @(posedge clk) begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire) begin
            step_speed_ramp(req_type, target_rpm);
        end
    end

    // input driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // hold until taken
        end else if (gap_left != 0) begin
            gap_left--;
            in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
            next_req = pending_requests.pop_front();
            req_type <= next_req.req;
            target_rpm <= next_req.rpm;
            in_valid <= 1'b1;
            gap_left = pick_pause(in_calm);
        end else begin
            in_valid <= 1'b0;
        end
    end

    // output back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_pause(out_calm);
        end
    end

    // output monitor
    always @(posedge clk) begin
        t_speed_word want;
        if (rst_n && out_valid && out_ready) begin
            if (speed_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected output word, freq %0d", step_frequency));
            end else begin
                want = speed_expected.pop_front();
                if (pwm_enable !== want.pwm)
                    report_mismatch($sformatf("pwm_enable %b, want %b", pwm_enable, want.pwm));
                if (period_reload !== want.reload)
                    report_mismatch($sformatf("period_reload %0d, want %0d",
                                              period_reload, want.reload));
                if (step_frequency !== want.freq)
                    report_mismatch($sformatf("step_frequency %0d, want %0d",
                                              step_frequency, want.freq));
                if (ramping !== want.ramping)
                    report_mismatch($sformatf("ramping %b, want %b", ramping, want.ramping));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int unsigned               phase;
        int unsigned               made;
        int unsigned               ticks;
        int unsigned               r;
        logic [ssr_pkg::REQ_W-1:0] kind;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: ;
                1: begin
                    write_register(ssr_pkg::CFG_MIN_FREQ, '0);
                    write_register(ssr_pkg::CFG_MAX_FREQ, '1);
                    write_register(ssr_pkg::CFG_ACCEL_STP, '1);
                    write_register(ssr_pkg::CFG_DECEL_STP, '1);
                end
                2: begin
                    // min above max, steps of zero hold a ramp in place
                    write_register(ssr_pkg::CFG_MIN_FREQ, '1);
                    write_register(ssr_pkg::CFG_MAX_FREQ, '0);
                    write_register(ssr_pkg::CFG_ACCEL_STP, '0);
                    write_register(ssr_pkg::CFG_DECEL_STP, '0);
                end
                3: begin
                    write_register(ssr_pkg::CFG_MIN_FREQ, 19'd5000);
                    write_register(ssr_pkg::CFG_MAX_FREQ, 19'd1000);
                    write_register(ssr_pkg::CFG_ACCEL_STP, 19'd250);
                    write_register(ssr_pkg::CFG_DECEL_STP, 19'd300);
                end
                4: begin
                    write_register(ssr_pkg::CFG_MIN_FREQ, 19'd1);
                    write_register(ssr_pkg::CFG_MAX_FREQ, 19'd500000);
                    write_register(ssr_pkg::CFG_ACCEL_STP, 19'd1);
                    write_register(ssr_pkg::CFG_DECEL_STP, 19'd1);
                end
                NUM_PHASES - 1: begin
                    write_register(ssr_pkg::CFG_MIN_FREQ, 19'd100);
                    write_register(ssr_pkg::CFG_MAX_FREQ, 19'd4000);
                    write_register(ssr_pkg::CFG_ACCEL_STP, 19'd100);
                    write_register(ssr_pkg::CFG_DECEL_STP, 19'd100);
                end
                default: begin
                    write_register(ssr_pkg::CFG_MIN_FREQ,
                                   ssr_pkg::FREQ_W'($urandom_range(0, 3000)));
                    write_register(ssr_pkg::CFG_MAX_FREQ,
                                   ssr_pkg::FREQ_W'($urandom_range(500, 220000)));
                    write_register(ssr_pkg::CFG_ACCEL_STP,
                                   ssr_pkg::FREQ_W'($urandom_range(1, 60000)));
                    write_register(ssr_pkg::CFG_DECEL_STP,
                                   ssr_pkg::FREQ_W'($urandom_range(1, 60000)));
                end
            endcase
            if (phase == 0) begin
                queue_item(ssr_pkg::REQ_TICK, '0);          // tick with nothing running
                queue_item(REQ_SPARE, '1);                  // unused code, ignored
                queue_item(ssr_pkg::REQ_DECEL, '0);         // stop with no step needed
                queue_item(ssr_pkg::REQ_ACCEL, 16'd1);      // raised to min
                queue_item(ssr_pkg::REQ_ACCEL, '1);         // cut to max
                repeat (3) queue_item(ssr_pkg::REQ_TICK, '1);
                queue_item(ssr_pkg::REQ_ACCEL, '0);         // goal below current
                queue_item(ssr_pkg::REQ_DECEL, '1);         // goal above current
                queue_item(ssr_pkg::REQ_ACCEL, 16'd1200);
                repeat (4) queue_item(ssr_pkg::REQ_TICK, '0);
                queue_item(ssr_pkg::REQ_DECEL, 16'd60);
                repeat (3) queue_item(ssr_pkg::REQ_TICK, '0);
                queue_item(ssr_pkg::REQ_DECEL, '0);         // ramp down then stop
                repeat (5) queue_item(ssr_pkg::REQ_TICK, '0);
                queue_item(REQ_SPARE, '0);
            end
            made = 0;
            while (made < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    kind = ($urandom_range(0, 1) != 0) ? ssr_pkg::REQ_DECEL : ssr_pkg::REQ_ACCEL;
                    queue_item(kind, pick_rpm());
                    ticks = $urandom_range(0, 40);
                    made += ticks + 1;
                    repeat (ticks) begin
                        if ($urandom_range(0, 19) == 0)
                            queue_item(REQ_SPARE, ssr_pkg::RPM_W'($urandom));
                        queue_item(ssr_pkg::REQ_TICK, ssr_pkg::RPM_W'($urandom));
                    end
                end else if (r < 90) begin
                    ticks = $urandom_range(1, 5);
                    made += ticks;
                    repeat (ticks) queue_item(ssr_pkg::REQ_TICK, ssr_pkg::RPM_W'($urandom));
                end else begin
                    kind = ssr_pkg::REQ_W'($urandom_range(0, 3));
                    queue_item(kind, pick_rpm());
                    if (kind != REQ_SPARE) made++;
                end
            end
            while (pending_requests.size() != 0 || in_valid || speed_expected.size() != 0)
                @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ssr_pkg.sv
rtl/ssr_front.sv
rtl/ssr_queue.sv
rtl/ssr_divider.sv
rtl/ssr_back.sv
rtl/stepper_speed_ramp_core.sv
sim/stepper_speed_ramp_core_test.sv
